// ===== rtl/core/lcg_pkg.sv =====
package lcg_pkg;

    // Fixed field widths of the item words
    localparam int OP_W  = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 6;

    // Default grid size
    localparam int GRID_ROWS_DEF = 64;
    localparam int GRID_COLS_DEF = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_FLIP    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    // B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_CNT   = 4'd3;
    localparam logic [3:0] SURVIVE_CNT = 4'd2;

    // Command broadcast from the front end to every row cell
    typedef struct packed {
        logic             flip;
        logic             advance;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] sel_row;
    } t_cmd;

    // Next state of one cell from its own state and its eight neighbors
    function automatic logic lcg_rule(input logic self, input logic [7:0] nb);
        logic [3:0] cnt;
        cnt = 4'($countones(nb));
        return (cnt == BIRTH_CNT) || (self && (cnt == SURVIVE_CNT));
    endfunction

endpackage

// ===== rtl/core/lcg_cell.sv =====
module lcg_cell
    import lcg_pkg::*;
#(
    parameter int COLS = GRID_COLS_DEF,
    parameter int IDX  = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  logic [COLS-1:0] i_col_hot,
    input  logic [COLS-1:0] i_sel_hot,
    input  logic [COLS-1:0] i_above,
    input  logic [COLS-1:0] i_below,
    output logic [COLS-1:0] o_row,
    output logic            o_tap
);

    logic [COLS-1:0] r_row;
    logic [COLS-1:0] n_row;
    logic [COLS-1:0] w_gen;
    logic [COLS+1:0] w_ext_a;
    logic [COLS+1:0] w_ext_s;
    logic [COLS+1:0] w_ext_b;
    logic            w_row_hit;
    logic            w_sel_hit;

    // Pad with dead cells past the left and right border
    assign w_ext_a = {1'b0, i_above, 1'b0};
    assign w_ext_s = {1'b0, r_row,   1'b0};
    assign w_ext_b = {1'b0, i_below, 1'b0};

    // Next generation, one column at a time
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            w_gen[c] = lcg_rule(w_ext_s[c+1],
                                {w_ext_a[c], w_ext_a[c+1], w_ext_a[c+2],
                                 w_ext_s[c],               w_ext_s[c+2],
                                 w_ext_b[c], w_ext_b[c+1], w_ext_b[c+2]});
        end
    end

    assign w_row_hit = (int'(i_cmd.row) == IDX);
    assign w_sel_hit = (int'(i_cmd.sel_row) == IDX);

    // Row update: generation step or single-cell flip
    always_comb begin
        n_row = r_row;
        if (i_cmd.advance) begin
            n_row = w_gen;
        end else if (i_cmd.flip && w_row_hit) begin
            n_row = r_row ^ i_col_hot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    // Contribution of this row to a pending read
    assign o_tap = w_sel_hit && |(r_row & i_sel_hot);
    assign o_row = r_row;

endmodule

// ===== rtl/core/life_cell_grid_engine.sv =====
// Game of Life (B3/S23) grid engine. The grid is held as a chain of row cells,
// one per grid row, each exchanging its row with the rows above and below every
// cycle; cells beyond the border count as dead and there is no wraparound. The
// grid is all dead right after reset, with no clearing pass. Every word is
// applied in the cycle it is accepted: a flip toggles one cell, an advance
// computes the whole next generation at once in the cell chain. The result word
// (the addressed cell after the operation, 0 for advance, for an unused op
// code, or for an address off the grid) is collected from the row taps in the
// read stage, which waits while the output register is held, and is then
// registered in the output register that offers it to the consumer.
// One word per cycle is sustained while the result side keeps up; the one-stage
// read collection and the output register set that.
module life_cell_grid_engine
    import lcg_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [OP_W-1:0]  i_op,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_alive
);

    logic                 w_accept;
    logic                 w_pend_move;
    logic                 r_pend;
    logic                 r_pend_rd;
    logic [ROW_W-1:0]     r_pend_row;
    logic [COL_W-1:0]     r_pend_col;
    logic                 r_out_valid;
    logic                 r_alive;
    t_cmd                 w_cmd;
    logic [GRID_COLS-1:0] w_col_hot;
    logic [GRID_COLS-1:0] w_sel_hot;
    logic [GRID_COLS-1:0] w_row [GRID_ROWS];
    logic [GRID_ROWS-1:0] w_tap;

    // Handshake: the read stage empties into the output register
    assign w_pend_move = r_pend && (!r_out_valid || i_ready);
    assign o_ready     = !r_pend || w_pend_move;
    assign w_accept    = i_valid && o_ready;

    // Column decode for the new word and for the pending read
    always_comb begin
        for (int j = 0; j < GRID_COLS; j++) begin
            w_col_hot[j] = (int'(i_col) == j);
            w_sel_hot[j] = (int'(r_pend_col) == j);
        end
    end

    // Command to the cells
    always_comb begin
        w_cmd.flip    = w_accept && (i_op == OP_FLIP);
        w_cmd.advance = w_accept && (i_op == OP_ADVANCE);
        w_cmd.row     = i_row;
        w_cmd.sel_row = r_pend_row;
    end

    // Row cell chain
    for (genvar i = 0; i < GRID_ROWS; i++) begin : g_cell
        logic [GRID_COLS-1:0] w_above;
        logic [GRID_COLS-1:0] w_below;

        if (i == 0) begin : g_top
            assign w_above = '0;
        end else begin : g_mid_a
            assign w_above = w_row[i-1];
        end

        if (i == GRID_ROWS - 1) begin : g_bot
            assign w_below = '0;
        end else begin : g_mid_b
            assign w_below = w_row[i+1];
        end

        lcg_cell #(
            .COLS (GRID_COLS),
            .IDX  (i)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_col_hot (w_col_hot),
            .i_sel_hot (w_sel_hot),
            .i_above   (w_above),
            .i_below   (w_below),
            .o_row     (w_row[i]),
            .o_tap     (w_tap[i])
        );
    end

    // Read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (w_accept) begin
            r_pend <= 1'b1;
        end else if (w_pend_move) begin
            r_pend <= 1'b0;
        end
    end

    // Read stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_rd  <= (i_op == OP_FLIP) || (i_op == OP_READ);
            r_pend_row <= i_row;
            r_pend_col <= i_col;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pend_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pend_move) begin
            r_alive <= r_pend_rd && (|w_tap);
        end
    end

    assign o_valid = r_out_valid;
    assign o_alive = r_alive;

    // An accepted word always occupies the read stage next cycle
    a_accept_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_pend)
        else $error("accepted word did not enter read stage");

    // Advance and unused op codes report a dead cell
    a_adv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pend_move && !r_pend_rd) |=> (o_valid && !o_alive))
        else $error("non-read result reported live cell");

    // A stalled read stage keeps its address
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !w_pend_move) |=> (r_pend && $stable(r_pend_row)
                                      && $stable(r_pend_col)))
        else $error("stalled read stage changed");

endmodule
